// ----- hw/rtl/yuv420_to_argb_converter_macros.svh -----
// assertion helpers for the top-level rtl file
`ifndef YUV420_TO_ARGB_CONVERTER_MACROS_SVH
`define YUV420_TO_ARGB_CONVERTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define Y2A_ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("y2a same-cycle check failed");

// next-cycle implication, checked out of reset
`define Y2A_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("y2a next-cycle check failed");

`endif

// ----- hw/rtl/y2a_pkg.sv -----
`timescale 1ns / 1ps

package y2a_pkg;

	// frame geometry
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;
	localparam int DIM_W      = 13;
	localparam int ROW_W      = 12;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int COL_W      = $clog2(LINE_DEPTH);
	localparam int PAIR_W     = $clog2(LINE_DEPTH + 1);
	localparam int WMAX_W     = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
	localparam int CHROMA_W   = 16;

	// queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int LVL_W   = $clog2(Q_DEPTH + 1);

	// datapath widths and bt.601 coefficients in 6-bit fixed point
	localparam int TERM_W = 16;
	localparam int ACC_W  = 18;
	localparam int FRAC_W = 6;
	localparam logic signed [ACC_W-1:0] COEF_Y  = ACC_W'(74);
	localparam logic signed [ACC_W-1:0] COEF_BU = ACC_W'(127);
	localparam logic signed [ACC_W-1:0] COEF_GU = -ACC_W'(25);
	localparam logic signed [ACC_W-1:0] COEF_GV = -ACC_W'(52);
	localparam logic signed [ACC_W-1:0] COEF_RV = ACC_W'(102);
	localparam logic [7:0] LUMA_OFS   = 8'd16;
	localparam logic [7:0] CHROMA_OFS = 8'd128;
	localparam logic [7:0] CHAN_MAX   = 8'd255;
	localparam logic [7:0] ALPHA      = 8'hFF;

	// configuration register indexes
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [7:0] luma_first;
		logic [7:0] luma_second;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
		logic       single;
		logic       last_pair;
		logic       last_row;
	} item_t;

endpackage

// ----- hw/rtl/yuv420_to_argb_converter.sv -----
`timescale 1ns / 1ps
// YUV 4:2:0 to ARGB converter, BT.601 in 6-bit fixed point, alpha fixed at 255.
// Each input item is one horizontal pixel pair in raster order and yields two
// pixels (one for the tail item of an odd-width row), one result per cycle while
// the output is not stalled; that rate is set by the single conversion datapath
// in the back end. The front end accepts items while the back end works, through
// a 4-entry queue. An accepted item passes the front-end stage register, the queue
// and the back-end item registers before reaching the output register. Odd rows reuse
// the chroma stored by the preceding even row in a 2048-entry line store that is
// not cleared after reset; the first row of a frame must therefore be even, as
// the position counters ensure. frame_width and frame_height may be written only
// while the block is idle; 0 acts as 1 and values above 4096 act as 4096.

module yuv420_to_argb_converter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [31:0]               s_axis_tdata,  // luma_first, luma_second, chroma_u, chroma_v
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [31:0]               m_axis_tdata,  // pixel_argb
	output logic                      m_axis_tlast,  // row_end
	output logic [1:0]                m_axis_tuser,  // frame_end, item_last
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  y2a_pkg::cfg_reg_t         cfg_index,
	input  logic [y2a_pkg::DIM_W-1:0] cfg_data
);

	import y2a_pkg::*;

`include "yuv420_to_argb_converter_macros.svh"

	logic             q_push;
	logic             q_pop;
	item_t            q_push_item;
	item_t            q_head_item;
	logic [LVL_W-1:0] q_level;

	// accept, classify, line store
	y2a_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_level      (q_level),
		.push         (q_push),
		.push_item    (q_push_item)
	);

	// decoupling queue
	y2a_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_push_item),
		.pop      (q_pop),
		.head_item(q_head_item),
		.level    (q_level)
	);

	// color conversion and output
	y2a_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_item    (q_head_item),
		.q_level      (q_level),
		.pop          (q_pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	// frame end only on a row end, row end only on an item's final pixel
	`Y2A_ASSERT_IMPL(a_frame_end_row_end, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
	`Y2A_ASSERT_IMPL(a_row_end_item_last, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1])
	// the queue never overflows or underflows
	`Y2A_ASSERT_IMPL(a_queue_no_overflow, q_push && !q_pop, q_level != LVL_W'(Q_DEPTH))
	`Y2A_ASSERT_IMPL(a_queue_no_underflow, q_pop, q_level != '0)
	// an accepted item reaches the queue on the next cycle
	`Y2A_ASSERT_NEXT(a_accept_to_queue, s_axis_tvalid && s_axis_tready, q_push)

endmodule

// ----- hw/rtl/y2a_ram.sv -----
`timescale 1ns / 1ps

module y2a_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- hw/rtl/y2a_front.sv -----
`timescale 1ns / 1ps

module y2a_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // luma_first, luma_second, chroma_u, chroma_v
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  y2a_pkg::cfg_reg_t           cfg_index,
	input  logic [y2a_pkg::DIM_W-1:0]   cfg_data,
	input  logic [y2a_pkg::LVL_W-1:0]   q_level,
	output logic                        push,
	output y2a_pkg::item_t              push_item
);

	import y2a_pkg::*;

	logic [DIM_W-1:0]    frame_width_q;
	logic [DIM_W-1:0]    frame_height_q;
	logic [COL_W-1:0]    column_pair_q;
	logic [ROW_W-1:0]    row_index_q;
	logic                valid_s1;
	logic                odd_row_s1;
	item_t               item_s1;
	logic [WMAX_W-1:0]   w_ext;
	logic [WMAX_W-1:0]   w_eff;
	logic [WMAX_W:0]     w_plus;
	logic [PAIR_W-1:0]   pairs;
	logic [DIM_W-1:0]    h_eff;
	logic                last_pair;
	logic                last_row;
	logic                accept;
	logic                odd_row;
	logic [LVL_W:0]      pending;
	logic [CHROMA_W-1:0] line_rdata;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= DIM_W'(64);
			frame_height_q <= DIM_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:          frame_width_q  <= frame_width_q;
			endcase
		end
	end

	// clamp geometry and classify the current position
	always_comb begin
		w_ext = WMAX_W'(frame_width_q);
		if (w_ext == '0) begin
			w_eff = WMAX_W'(1);
		end else if (w_ext > WMAX_W'(MAX_WIDTH)) begin
			w_eff = WMAX_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		w_plus = ({1'b0, w_eff} + (WMAX_W+1)'(1)) >> 1;
		pairs  = w_plus[PAIR_W-1:0];
		if (frame_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (frame_height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = frame_height_q;
		end
		last_pair = (PAIR_W'(column_pair_q) + PAIR_W'(1)) >= pairs;
		last_row  = (DIM_W'(row_index_q) + DIM_W'(1)) >= h_eff;
	end

	// room for the queued items plus the one in flight
	assign pending       = (LVL_W+1)'(q_level) + (LVL_W+1)'(valid_s1);
	assign s_axis_tready = pending < (LVL_W+1)'(Q_DEPTH);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign odd_row       = row_index_q[0];

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pair_q <= '0;
			row_index_q   <= '0;
			valid_s1      <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_pair) begin
					column_pair_q <= '0;
					row_index_q   <= last_row ? '0 : row_index_q + ROW_W'(1);
				end else begin
					column_pair_q <= column_pair_q + COL_W'(1);
				end
			end
		end
	end

	// classified item is registered while the line store read completes
	always_ff @(posedge clk) begin
		if (accept) begin
			odd_row_s1            <= odd_row;
			item_s1.luma_first    <= s_axis_tdata[7:0];
			item_s1.luma_second   <= s_axis_tdata[15:8];
			item_s1.chroma_u      <= s_axis_tdata[23:16];
			item_s1.chroma_v      <= s_axis_tdata[31:24];
			item_s1.single        <= last_pair && w_eff[0];
			item_s1.last_pair     <= last_pair;
			item_s1.last_row      <= last_row;
		end
	end

	// chroma line store: even rows write, odd rows read
	y2a_ram #(
		.WIDTH(CHROMA_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (accept && !odd_row),
		.addr (column_pair_q),
		.wdata({s_axis_tdata[31:24], s_axis_tdata[23:16]}),
		.rdata(line_rdata)
	);

	// odd rows take the stored chroma pair
	always_comb begin
		push_item = item_s1;
		if (odd_row_s1) begin
			push_item.chroma_u = line_rdata[7:0];
			push_item.chroma_v = line_rdata[15:8];
		end
	end

	assign push = valid_s1;

endmodule

// ----- hw/rtl/y2a_queue.sv -----
`timescale 1ns / 1ps

module y2a_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  y2a_pkg::item_t            push_item,
	input  logic                      pop,
	output y2a_pkg::item_t            head_item,
	output logic [y2a_pkg::LVL_W-1:0] level
);

	import y2a_pkg::*;

	item_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0]   level_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign head_item = entry_q[rd_ptr_q];
	assign level     = level_q;

endmodule

// ----- hw/rtl/y2a_back.sv -----
`timescale 1ns / 1ps

module y2a_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  y2a_pkg::item_t            head_item,
	input  logic [y2a_pkg::LVL_W-1:0] q_level,
	output logic                      pop,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [31:0]               m_axis_tdata,  // pixel_argb
	output logic                      m_axis_tlast,  // row_end
	output logic [1:0]                m_axis_tuser   // frame_end, item_last
);

	import y2a_pkg::*;

	logic                     busy_q;
	logic                     phase_q;
	logic [7:0]               luma_first_q;
	logic [7:0]               luma_second_q;
	logic                     single_q;
	logic                     last_pair_q;
	logic                     last_row_q;
	logic signed [TERM_W-1:0] term_b_q;
	logic signed [TERM_W-1:0] term_g_q;
	logic signed [TERM_W-1:0] term_r_q;
	logic                     m_valid_q;
	logic [31:0]              m_data_q;
	logic                     m_row_end_q;
	logic                     m_frame_end_q;
	logic                     m_item_last_q;
	logic                     advance;
	logic                     fin;
	logic                     load;
	logic signed [ACC_W-1:0]  cu;
	logic signed [ACC_W-1:0]  cv;
	logic signed [ACC_W-1:0]  tb_full;
	logic signed [ACC_W-1:0]  tg_full;
	logic signed [ACC_W-1:0]  tr_full;
	logic [7:0]               luma;
	logic signed [ACC_W-1:0]  dy;
	logic signed [ACC_W-1:0]  acc_b;
	logic signed [ACC_W-1:0]  acc_g;
	logic signed [ACC_W-1:0]  acc_r;

	// floor shift then clamp to 0..255
	function automatic logic [7:0] sat_channel(input logic signed [ACC_W-1:0] acc);
		logic [ACC_W-FRAC_W-2:0] sh;
		sh = acc[ACC_W-2:FRAC_W];
		if (acc[ACC_W-1]) begin
			return 8'd0;
		end else if (sh > (ACC_W-FRAC_W-1)'(CHAN_MAX)) begin
			return CHAN_MAX;
		end else begin
			return sh[7:0];
		end
	endfunction

	assign advance = !m_valid_q || m_axis_tready;
	assign fin     = busy_q && (phase_q || single_q);
	assign load    = advance && (!busy_q || fin) && (q_level != '0);
	assign pop     = load;

	// chroma terms of the queue head, taken when it loads
	always_comb begin
		cu      = ACC_W'(head_item.chroma_u) - ACC_W'(CHROMA_OFS);
		cv      = ACC_W'(head_item.chroma_v) - ACC_W'(CHROMA_OFS);
		tb_full = cu * COEF_BU;
		tg_full = cu * COEF_GU + cv * COEF_GV;
		tr_full = cv * COEF_RV;
	end

	// item sequencing: one pixel per cycle while the output advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (advance) begin
			if (load) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			luma_first_q  <= head_item.luma_first;
			luma_second_q <= head_item.luma_second;
			single_q      <= head_item.single;
			last_pair_q   <= head_item.last_pair;
			last_row_q    <= head_item.last_row;
			term_b_q      <= tb_full[TERM_W-1:0];
			term_g_q      <= tg_full[TERM_W-1:0];
			term_r_q      <= tr_full[TERM_W-1:0];
		end
	end

	// per-pixel luma term plus stored chroma terms
	always_comb begin
		luma  = phase_q ? luma_second_q : luma_first_q;
		dy    = (ACC_W'(luma) - ACC_W'(LUMA_OFS)) * COEF_Y;
		acc_b = dy + ACC_W'(term_b_q);
		acc_g = dy + ACC_W'(term_g_q);
		acc_r = dy + ACC_W'(term_r_q);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && busy_q) begin
			m_data_q      <= {ALPHA, sat_channel(acc_r), sat_channel(acc_g), sat_channel(acc_b)};
			m_row_end_q   <= fin && last_pair_q;
			m_frame_end_q <= fin && last_pair_q && last_row_q;
			m_item_last_q <= fin;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_row_end_q;
	assign m_axis_tuser  = {m_item_last_q, m_frame_end_q};

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import y2a_pkg::*;

	localparam int ITEM_TARGET  = 1050;
	localparam int LONG_STALL   = 200;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [31:0] argb;
		logic        row_end;
		logic        frame_end;
		logic        item_last;
	} pixel_result_t;

	typedef enum int {
		SINK_READY,
		SINK_COIN,
		SINK_EVERY_THIRD
	} sink_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;   // luma_first, luma_second, chroma_u, chroma_v
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;   // pixel_argb
	logic                 m_axis_tlast;   // row_end
	logic [1:0]           m_axis_tuser;   // frame_end, item_last
	logic                 cfg_valid;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index;
	logic [DIM_W-1:0]     cfg_data;

	// expected pixels and the predictor's copy of the block state
	pixel_result_t        pending_pixels[$];
	logic [DIM_W-1:0]     geo_width  = 13'd64;
	logic [DIM_W-1:0]     geo_height = 13'd64;
	logic [15:0]          chroma_store [LINE_DEPTH];
	int                   pos_col = 0;
	int                   pos_row = 0;

	int                   fail_count  = 0;
	int                   items_sent  = 0;
	int                   burst_left  = 0;
	int                   quiet_cycles = 0;
	bit                   long_stall_req = 1'b0;

	yuv420_to_argb_converter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 50 MHz clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// bt.601 channel: floor shift by 6, clamp to 0..255
	function automatic logic [7:0] clamp_channel(input int acc);
		int scaled;
		if (acc < 0)
			return 8'd0;
		scaled = acc >>> 6;
		return (scaled > 255) ? 8'd255 : scaled[7:0];
	endfunction

	function automatic logic [31:0] argb_of(input logic [7:0] y, input logic [7:0] u,
			input logic [7:0] v);
		int luma_term;
		int cu;
		int cv;
		luma_term = (int'(y) - 16) * 74;
		cu = int'(u) - 128;
		cv = int'(v) - 128;
		return {8'hFF, clamp_channel(luma_term + 102 * cv),
			clamp_channel(luma_term - 25 * cu - 52 * cv), clamp_channel(luma_term + 127 * cu)};
	endfunction

	// expected pixels for one accepted pair, and position update
	task automatic predict_pair(input logic [31:0] item);
		int w;
		int h;
		int pairs;
		int n;
		logic [7:0] u;
		logic [7:0] v;
		logic last_pair;
		logic last_row;
		logic [31:0] px [2];
		pixel_result_t r;
		w = geo_width;
		h = geo_height;
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		if (h < 1) h = 1;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		pairs = (w + 1) / 2;
		last_pair = (pos_col + 1 >= pairs);
		last_row = (pos_row + 1 >= h);
		// even rows store chroma, odd rows reuse it
		if (pos_row % 2 == 0) begin
			u = item[23:16];
			v = item[31:24];
			chroma_store[pos_col] = {v, u};
		end else begin
			{v, u} = chroma_store[pos_col];
		end
		px[0] = argb_of(item[7:0], u, v);
		px[1] = argb_of(item[15:8], u, v);
		n = (last_pair && w[0]) ? 1 : 2;
		for (int k = 0; k < n; k++) begin
			r.argb = px[k];
			r.item_last = (k == n - 1);
			r.row_end = r.item_last && last_pair;
			r.frame_end = r.row_end && last_row;
			pending_pixels.push_back(r);
		end
		if (last_pair) begin
			pos_col = 0;
			pos_row = last_row ? 0 : pos_row + 1;
		end else begin
			pos_col++;
		end
	endtask

	// predictor follows accepted items and register writes
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predict_pair(s_axis_tdata);
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH: geo_width = cfg_data;
				REG_FRAME_HEIGHT: geo_height = cfg_data;
				default: ;
			endcase
		end
	end

	task automatic note_mismatch(input string what, input pixel_result_t e,
			input pixel_result_t g);
		if (fail_count < 10)
			$display("mismatch (%s): expected argb=%08h row_end=%0b frame_end=%0b last=%0b,",
				what, e.argb, e.row_end, e.frame_end, e.item_last,
				" got argb=%08h row_end=%0b frame_end=%0b last=%0b",
				g.argb, g.row_end, g.frame_end, g.item_last);
		fail_count++;
	endtask

	// compare each output pixel with the oldest expectation
	always @(posedge clk) begin : check_pixels
		pixel_result_t exp_px;
		pixel_result_t got_px;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_px.argb = m_axis_tdata;
			got_px.row_end = m_axis_tlast;
			got_px.frame_end = m_axis_tuser[0];
			got_px.item_last = m_axis_tuser[1];
			if (pending_pixels.size() == 0) begin
				note_mismatch("no pixel expected", '0, got_px);
			end else begin
				exp_px = pending_pixels.pop_front();
				if (got_px.argb !== exp_px.argb || got_px.row_end !== exp_px.row_end ||
						got_px.frame_end !== exp_px.frame_end ||
						got_px.item_last !== exp_px.item_last)
					note_mismatch("pixel", exp_px, got_px);
			end
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QUIET_LIMIT) begin
				$display("** yuv420_to_argb_converter: FAILED **");
				$finish;
			end
		end
	end

	// output ready pattern, with a long hold-off on request
	initial begin : pixel_sink
		sink_mode_t sink_mode;
		int seg_left;
		int phase_cnt;
		sink_mode = SINK_READY;
		seg_left = 0;
		phase_cnt = 0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_req = 1'b0;
			end else begin
				if (seg_left == 0) begin
					sink_mode = sink_mode_t'($urandom_range(0, 2));
					seg_left = $urandom_range(16, 160);
				end
				seg_left--;
				phase_cnt++;
				case (sink_mode)
					SINK_READY: m_axis_tready <= 1'b1;
					SINK_COIN: m_axis_tready <= $urandom_range(0, 1);
					SINK_EVERY_THIRD: m_axis_tready <= (phase_cnt % 3 != 0);
					default: m_axis_tready <= 1'b1;
				endcase
			end
		end
	end

	task automatic hold_input(input int n);
		if (n > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// offer one pixel pair, in bursts with random gaps
	task automatic send_pixel_pair(input logic [7:0] y0, input logic [7:0] y1,
			input logic [7:0] u, input logic [7:0] v);
		if (burst_left == 0) begin
			hold_input(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {v, u, y1, y0};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// wait until every expected pixel has come out
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [DIM_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// sample value, biased toward the ends of the range
	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	task automatic send_random_pair();
		send_pixel_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
	endtask

	// default geometry, then width and height changed mid-frame
	task automatic test_midframe_geometry();
		send_pixel_pair(8'd0, 8'd255, 8'd0, 8'd0);
		send_pixel_pair(8'd255, 8'd0, 8'd255, 8'd255);
		send_pixel_pair(8'd16, 8'd235, 8'd128, 8'd128);
		send_pixel_pair(8'd128, 8'd64, 8'd0, 8'd255);
		// narrower row ends here, odd width gives a single pixel
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd5);
		send_pixel_pair(8'd235, 8'd16, 8'd255, 8'd0);
		// odd row becomes the last row
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_pixel_pair(8'd255, 8'd255, 8'd7, 8'd7);
		send_pixel_pair(8'd0, 8'd0, 8'd9, 8'd9);
		send_pixel_pair(8'd16, 8'd16, 8'd1, 8'd2);
	endtask

	// one-pixel frames, and zero sizes acting as one
	task automatic test_degenerate_sizes();
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd1);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		send_pixel_pair(8'd255, 8'd255, 8'd255, 8'd255);
		send_pixel_pair(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel_pair(8'd81, 8'd145, 8'd90, 8'd240);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		send_pixel_pair(8'd41, 8'd240, 8'd240, 8'd110);
		send_pixel_pair(8'd210, 8'd16, 8'd16, 8'd146);
	endtask

	// full-scale register values, then a mid-row shrink to close the frame
	task automatic test_oversize_geometry();
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		repeat (5) send_random_pair();
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd6);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		repeat (4) send_random_pair();
	endtask

	// output held off while input keeps coming
	task automatic test_output_backpressure();
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 13'd10);
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		long_stall_req = 1'b1;
		repeat (20) send_random_pair();
	endtask

	// whole frames with random geometry
	task automatic test_random_frames();
		int w;
		int h;
		int frames;
		while (items_sent < ITEM_TARGET) begin
			wait_drained();
			case ($urandom_range(0, 15))
				0: w = 0;
				1: w = 1;
				2: w = 2;
				3: w = $urandom_range(64, 256);
				default: w = $urandom_range(3, 40);
			endcase
			h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 3) != 0 || w != geo_width)
				write_reg(REG_FRAME_WIDTH, w[DIM_W-1:0]);
			if ($urandom_range(0, 3) != 0 || h != geo_height)
				write_reg(REG_FRAME_HEIGHT, h[DIM_W-1:0]);
			if (w < 1) w = 1;
			if (h < 1) h = 1;
			frames = $urandom_range(1, 2);
			repeat (frames * h * ((w + 1) / 2)) send_random_pair();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_FRAME_WIDTH;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_midframe_geometry();
		test_degenerate_sizes();
		test_oversize_geometry();
		test_output_backpressure();
		test_random_frames();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			if (fail_count < 10)
				$display("%0d expected pixels never came out", pending_pixels.size());
			fail_count += pending_pixels.size();
		end
		if (fail_count == 0)
			$display("** yuv420_to_argb_converter: PASSED **");
		else
			$display("** yuv420_to_argb_converter: FAILED **");
		$finish;
	end

endmodule
